>>> sv/cpt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpt_pkg
// Shared types, codes and default sizes for the CPT count accumulator.
// ---------------------------------------------------------------------------
package cpt_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_NODES       = 16;
    localparam int DEF_CPT_ENTRIES = 256;
    localparam int DEF_MAX_PARENTS = 3;
    localparam int DEF_COUNT_BITS  = 32;

    // Position / table-size arithmetic: 31^4 < 2^20
    localparam int POS_W = 20;

    // Operation codes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Layout register codes
    localparam logic LAYOUT_NODE_LSB = 1'b0;
    localparam logic LAYOUT_NODE_MSB = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VALUE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG   = 2'd2;

    // One request
    typedef struct packed {
        logic       op;
        logic [3:0] node_id;
        logic [3:0] node_value;
        logic [4:0] node_card;
        logic [1:0] num_parents;
        logic [3:0] par_value_a;
        logic [3:0] par_value_b;
        logic [3:0] par_value_c;
        logic [4:0] par_card_a;
        logic [4:0] par_card_b;
        logic [4:0] par_card_c;
    } t_req;

    // One result
    typedef struct packed {
        logic [7:0]  position;
        logic [31:0] count_value;
        logic [1:0]  status;
    } t_rsp;

endpackage
`default_nettype wire

>>> sv/cpt_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpt_req_if
// Valid/ready channel carrying one counting request.
// ---------------------------------------------------------------------------
interface cpt_req_if;
    logic          valid;
    logic          ready;
    cpt_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/cpt_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpt_rsp_if
// Valid/ready channel carrying one counting result.
// ---------------------------------------------------------------------------
interface cpt_rsp_if;
    logic          valid;
    logic          ready;
    cpt_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/cpt_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpt_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module cpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> sv/cpt_count_accumulator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpt_count_accumulator
// Per-node CPT occurrence counter with saturating read-modify-write.
// ---------------------------------------------------------------------------
// After reset the block sweeps the count memory to zero, one entry per cycle,
// over all NODES*CPT_ENTRIES entries (4096 at the defaults), and accepts no
// request until the sweep is done; layout writes are taken at any time.
// Requests are then handled one at a time: the table position and table size
// are built by a digit-serial multiply-add, one digit (node or parent) per
// cycle, followed by a check cycle that issues the memory read, a modify
// cycle that writes the count back, and a step that loads the output register
// once any earlier result has been claimed. A request that ends in an error
// skips the modify cycle. The result waits in the output register, so the
// next request is taken while it is still unclaimed.
// ---------------------------------------------------------------------------
module cpt_count_accumulator #(
    parameter int NODES       = cpt_pkg::DEF_NODES,
    parameter int CPT_ENTRIES = cpt_pkg::DEF_CPT_ENTRIES,
    parameter int MAX_PARENTS = cpt_pkg::DEF_MAX_PARENTS,
    parameter int COUNT_BITS  = cpt_pkg::DEF_COUNT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic  i_cfg_wr_data,
    cpt_req_if.sink    i_req,
    cpt_rsp_if.source  o_rsp
);
    import cpt_pkg::*;

    localparam int DEPTH = NODES * CPT_ENTRIES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [POS_W-1:0] ENTRIES_W = POS_W'(CPT_ENTRIES);
    localparam logic [6:0]       NODES_W   = 7'(NODES);
    localparam logic [1:0]       MAX_PAR_W = 2'(MAX_PARENTS);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic                  r_layout, n_layout;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;
    t_rsp                  r_pend, n_pend;
    t_req                  r_item, n_item;
    logic [1:0]            r_np, n_np;
    logic [1:0]            r_k, n_k;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      r_mult, n_mult;
    logic                  r_bad, n_bad;
    logic [AW-1:0]         r_addr, n_addr;

    logic                  req_fire;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         tbl_addr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_next;
    logic [1:0]            par_idx;
    logic                  is_node;
    logic [3:0]            dig_val;
    logic [4:0]            dig_card;
    logic [1:0]            chk_status;

    // count memory
    cpt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (tbl_addr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign req_fire      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // digit select: least significant digit first
    always_comb begin
        if (r_layout == LAYOUT_NODE_LSB) begin
            is_node = (r_k == 2'd0);
            par_idx = r_np - r_k;
        end else begin
            is_node = (r_k == r_np);
            par_idx = r_k;
        end
        case (par_idx)
            2'd0:    begin dig_val = r_item.par_value_a; dig_card = r_item.par_card_a; end
            2'd1:    begin dig_val = r_item.par_value_b; dig_card = r_item.par_card_b; end
            default: begin dig_val = r_item.par_value_c; dig_card = r_item.par_card_c; end
        endcase
        if (is_node) begin
            dig_val  = r_item.node_value;
            dig_card = r_item.node_card;
        end
    end

    // status once all digits are in
    always_comb begin
        if (r_bad) begin
            chk_status = ST_BAD_VALUE;
        end else if ((r_mult > ENTRIES_W) || ({3'b000, r_item.node_id} >= NODES_W)) begin
            chk_status = ST_TOO_BIG;
        end else begin
            chk_status = ST_OK;
        end
    end

    // table entry address, read in the check cycle
    assign tbl_addr = AW'(r_item.node_id) * AW'(CPT_ENTRIES) + AW'(r_pos);

    // saturating increment for a count request; a query keeps the value read
    assign cnt_next = ((r_item.op == OP_COUNT) && !(&ram_rdata)) ? ram_rdata + 1'b1
                                                                  : ram_rdata;

    // memory write: clearing sweep or count write-back
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_MOD);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : cnt_next;
    assign ram_re    = (r_state == S_CHK);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_layout    = r_layout;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pend      = r_pend;
        n_item      = r_item;
        n_np        = r_np;
        n_k         = r_k;
        n_pos       = r_pos;
        n_mult      = r_mult;
        n_bad       = r_bad;
        n_addr      = r_addr;

        if (i_cfg_wr_en) begin
            n_layout = i_cfg_wr_data;
        end
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_item  = i_req.payload;
                    n_np    = (i_req.payload.num_parents > MAX_PAR_W) ? MAX_PAR_W
                                                                      : i_req.payload.num_parents;
                    n_k     = 2'd0;
                    n_pos   = '0;
                    n_mult  = POS_W'(1);
                    n_bad   = 1'b0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_pos  = r_pos + POS_W'(dig_val * r_mult);
                n_mult = POS_W'(r_mult * dig_card);
                n_bad  = r_bad || ({1'b0, dig_val} >= dig_card);
                n_k    = r_k + 1'b1;
                if (r_k == r_np) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_addr = tbl_addr;
                if (chk_status == ST_OK) begin
                    n_state = S_MOD;
                end else begin
                    n_pend.position    = '0;
                    n_pend.count_value = '0;
                    n_pend.status      = chk_status;
                    n_state            = S_OUT;
                end
            end
            S_MOD: begin
                n_pend.position    = r_pos[7:0];
                n_pend.count_value = 32'(64'(cnt_next));
                n_pend.status      = ST_OK;
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_layout    <= LAYOUT_NODE_LSB;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_layout    <= n_layout;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        r_item <= n_item;
        r_np   <= n_np;
        r_k    <= n_k;
        r_pos  <= n_pos;
        r_mult <= n_mult;
        r_bad  <= n_bad;
        r_addr <= n_addr;
    end

    // a count write-back never wraps below the value read
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (ram_wdata >= ram_rdata))
        else $error("count write-back wrapped");

    // a position that reaches memory lies inside the node's table
    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_pos < ENTRIES_W))
        else $error("position outside table");

    // the clearing sweep runs to the last entry before requests are taken
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && (r_clr != LAST_ADDR)) |=> (r_state == S_CLEAR))
        else $error("clearing sweep ended early");

endmodule
`default_nettype wire
